>>> hw/rtl/cfpd_pkg.sv
package cfpd_pkg;

  // register file layout, byte address is 4 * index
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN_DT = 3'd1,
    REG_DERIV_GAIN_DT = 3'd2,
    REG_FOLLOW_RANGE  = 3'd3,
    REG_CUTOFF_LEVEL  = 3'd4,
    REG_MINIMUM_DRIVE = 3'd5
  } cfg_reg_e;

  localparam logic [23:0] PropGainRst  = 24'd196608;
  localparam logic [23:0] IntegGainRst = 24'd328;
  localparam logic [23:0] DerivGainRst = 24'd26214;
  localparam logic [15:0] FollowRngRst = 16'd8000;
  localparam logic [7:0]  CutoffRst    = 8'd50;
  localparam logic [7:0]  MinDriveRst  = 8'd100;

  // integral product limit, +-2^48
  localparam logic signed [64:0] ItermPosLim = 65'sd281474976710656;
  localparam logic signed [64:0] ItermNegLim = -65'sd281474976710656;

  // error integrator saturation bounds
  localparam logic signed [39:0] SumMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SumMin = {1'b1, {39{1'b0}}};

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain_dt;
    logic [23:0] deriv_gain_per_dt;
    logic [15:0] follow_range;
    logic [7:0]  cutoff_level;
    logic [7:0]  minimum_drive;
  } cfg_t;

endpackage

>>> hw/rtl/cfpd_regs.sv
module cfpd_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cfpd_pkg::AddrWidth-1:0]   paddr,
  input  logic [cfpd_pkg::DataWidth-1:0]   pwdata,
  output logic [cfpd_pkg::DataWidth-1:0]   prdata,
  output logic                             pready,
  output cfpd_pkg::cfg_t                   cfg_o
);

  cfpd_pkg::cfg_t    cfg_q;
  cfpd_pkg::cfg_t    cfg_d;
  cfpd_pkg::cfg_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfpd_pkg::cfg_reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        cfpd_pkg::REG_PROP_GAIN:     cfg_d.prop_gain         = pwdata[23:0];
        cfpd_pkg::REG_INTEG_GAIN_DT: cfg_d.integ_gain_dt     = pwdata[23:0];
        cfpd_pkg::REG_DERIV_GAIN_DT: cfg_d.deriv_gain_per_dt = pwdata[23:0];
        cfpd_pkg::REG_FOLLOW_RANGE:  cfg_d.follow_range      = pwdata[15:0];
        cfpd_pkg::REG_CUTOFF_LEVEL:  cfg_d.cutoff_level      = pwdata[7:0];
        cfpd_pkg::REG_MINIMUM_DRIVE: cfg_d.minimum_drive     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cfpd_pkg::REG_PROP_GAIN:     prdata = {8'd0, cfg_q.prop_gain};
      cfpd_pkg::REG_INTEG_GAIN_DT: prdata = {8'd0, cfg_q.integ_gain_dt};
      cfpd_pkg::REG_DERIV_GAIN_DT: prdata = {8'd0, cfg_q.deriv_gain_per_dt};
      cfpd_pkg::REG_FOLLOW_RANGE:  prdata = {16'd0, cfg_q.follow_range};
      cfpd_pkg::REG_CUTOFF_LEVEL:  prdata = {24'd0, cfg_q.cutoff_level};
      cfpd_pkg::REG_MINIMUM_DRIVE: prdata = {24'd0, cfg_q.minimum_drive};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain         <= cfpd_pkg::PropGainRst;
      cfg_q.integ_gain_dt     <= cfpd_pkg::IntegGainRst;
      cfg_q.deriv_gain_per_dt <= cfpd_pkg::DerivGainRst;
      cfg_q.follow_range      <= cfpd_pkg::FollowRngRst;
      cfg_q.cutoff_level      <= cfpd_pkg::CutoffRst;
      cfg_q.minimum_drive     <= cfpd_pkg::MinDriveRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/cruise_follow_pid_drive.sv
// a beat accepted at the input passes the stage 1, 2, 3 and 4 registers in order,
//   shows on the output from the stage 4 register and leaves when out_stall_i is low
// throughput: one beat per cycle when the output does not stall, a four stage pipeline
//   (state update, partial products, integral merge and clamp, final sum and deadband)
// stall on the output backs up stage by stage, bubbles keep input open
// reset: gains and deadband back to defaults, integrator and last error
//   cleared, first tick flag set, pipeline emptied
module cruise_follow_pid_drive (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfpd_pkg::AddrWidth-1:0] paddr,
  input  logic [cfpd_pkg::DataWidth-1:0] pwdata,
  output logic [cfpd_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [15:0]                    host_speed_i,
  input  logic [15:0]                    lead_speed_i,
  input  logic [15:0]                    target_speed_i,
  input  logic [15:0]                    lead_gap_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     drive_request_o,
  output logic                           follow_mode_o
);

  cfpd_pkg::cfg_t cfg;

  cfpd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------
  // pipeline flow control: each stage loads when empty or when it drains
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  assign rdy4   = !v4_q || !out_stall_i;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign in_acc = in_valid_i && rdy1;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: mode select, speed error, integrator and difference
  // ---------------------------------------------------------------------
  logic                follow_d;
  logic [15:0]         goal;
  logic signed [16:0]  err_d;
  logic signed [40:0]  sum_ext;
  logic signed [39:0]  error_sum_d, error_sum_q;
  logic signed [16:0]  last_error_q;
  logic                first_tick_q;
  logic signed [17:0]  diff_d;

  // cruise when the lead outruns the set speed or sits beyond the range
  assign follow_d = !((lead_speed_i > target_speed_i) || (lead_gap_i > cfg.follow_range));
  assign goal     = follow_d ? lead_speed_i : target_speed_i;
  assign err_d    = $signed({1'b0, goal}) - $signed({1'b0, host_speed_i});

  // saturating 40 bit accumulate
  assign sum_ext = {error_sum_q[39], error_sum_q} + {{24{err_d[16]}}, err_d};
  always_comb begin
    if (sum_ext[40] != sum_ext[39]) begin
      error_sum_d = sum_ext[40] ? cfpd_pkg::SumMin : cfpd_pkg::SumMax;
    end else begin
      error_sum_d = sum_ext[39:0];
    end
  end

  // no derivative kick on the very first beat
  assign diff_d = first_tick_q ? 18'sd0
                : ({err_d[16], err_d} - {last_error_q[16], last_error_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
      first_tick_q <= 1'b1;
    end else if (in_acc) begin
      error_sum_q  <= error_sum_d;
      last_error_q <= err_d;
      first_tick_q <= 1'b0;
    end
  end

  logic signed [16:0] err1_q;
  logic signed [17:0] diff1_q;
  logic signed [39:0] sum1_q;
  logic               follow1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      err1_q    <= err_d;
      diff1_q   <= diff_d;
      sum1_q    <= error_sum_d;
      follow1_q <= follow_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: products, the 24x40 integral product split into two halves
  // ---------------------------------------------------------------------
  logic signed [41:0] p2_d, p2_q;
  logic signed [42:0] d2_d, d2_q;
  logic [43:0]        ilo2_d, ilo2_q;
  logic signed [44:0] ihi2_d, ihi2_q;
  logic               follow2_q;

  assign p2_d   = $signed({1'b0, cfg.prop_gain}) * err1_q;
  assign d2_d   = $signed({1'b0, cfg.deriv_gain_per_dt}) * diff1_q;
  assign ilo2_d = cfg.integ_gain_dt * sum1_q[19:0];
  assign ihi2_d = $signed({1'b0, cfg.integ_gain_dt}) * $signed(sum1_q[39:20]);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p2_q      <= p2_d;
      d2_q      <= d2_d;
      ilo2_q    <= ilo2_d;
      ihi2_q    <= ihi2_d;
      follow2_q <= follow1_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: merge integral halves and limit to +-2^48, sum P and D
  // ---------------------------------------------------------------------
  logic signed [64:0] iterm_full;
  logic signed [49:0] iterm3_d, iterm3_q;
  logic signed [43:0] pd3_d, pd3_q;
  logic               follow3_q;

  assign iterm_full = $signed({ihi2_q, 20'd0}) + $signed({21'd0, ilo2_q});

  always_comb begin
    if (iterm_full > cfpd_pkg::ItermPosLim) begin
      iterm3_d = cfpd_pkg::ItermPosLim[49:0];
    end else if (iterm_full < cfpd_pkg::ItermNegLim) begin
      iterm3_d = cfpd_pkg::ItermNegLim[49:0];
    end else begin
      iterm3_d = iterm_full[49:0];
    end
  end

  assign pd3_d = {{2{p2_q[41]}}, p2_q} + {d2_q[42], d2_q};

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      iterm3_q  <= iterm3_d;
      pd3_q     <= pd3_d;
      follow3_q <= follow2_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: total, byte clamp, deadband
  // ---------------------------------------------------------------------
  logic signed [51:0] total;
  logic [7:0]         level;
  logic [7:0]         drive_d, drive_q;
  logic               follow4_q;

  assign total = {{8{pd3_q[43]}}, pd3_q} + {{2{iterm3_q[49]}}, iterm3_q};

  always_comb begin
    if (total[51] || (total == 52'sd0)) begin
      level = 8'd0;
    end else if (|total[50:32]) begin
      level = 8'd255;
    end else begin
      level = total[31:24];
    end
  end

  always_comb begin
    if (level < cfg.cutoff_level) begin
      drive_d = 8'd0;
    end else if (level < cfg.minimum_drive) begin
      drive_d = cfg.minimum_drive;
    end else begin
      drive_d = level;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      drive_q   <= drive_d;
      follow4_q <= follow3_q;
    end
  end

  assign out_valid_o     = v4_q;
  assign drive_request_o = drive_q;
  assign follow_mode_o   = follow4_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // stall only while the first stage holds a beat it cannot pass on
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q)
    else $error("input stalled with empty first stage");

  // integrator only moves on an accepted beat
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(error_sum_q) && $stable(last_error_q))
    else $error("controller state changed without a beat");

  // first tick flag never comes back without reset
  a_first_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_tick_q |=> !first_tick_q)
    else $error("first tick flag set again");

  // a new output beat always comes from a full third stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v4_q) |-> $past(v3_q))
    else $error("output valid without a beat in stage three");

endmodule
